/* rtl/mp3fh_pkg.sv */
// ============================================================================
// mp3fh_pkg
// Shared types, constants and lookup functions of the MPEG audio Layer III
// frame header analyzer.
// ============================================================================
package mp3fh_pkg;

    // Frame size limits.
    localparam int unsigned MAX_FRAME_BYTES = 1441;
    localparam int unsigned MIN_FRAME_BYTES = 24;

    // Header codes.
    localparam logic [10:0] SYNC_WORD    = 11'h7FF;
    localparam logic [1:0]  VER_MPEG1    = 2'd3;
    localparam logic [1:0]  VER_RESERVED = 2'd1;
    localparam logic [3:0]  BR_FREE      = 4'd0;
    localparam logic [3:0]  BR_BAD       = 4'd15;
    localparam logic [1:0]  SR_RESERVED  = 2'd3;
    localparam logic [1:0]  MODE_MONO    = 2'b11;

    // Samples per frame over eight, times 1000 (the rate tables are in kbit/s).
    localparam logic [17:0] SCALE_MPEG1 = 18'd144000;
    localparam logic [17:0] SCALE_MPEG2 = 18'd72000;

    // Datapath widths.
    localparam int NUM_W  = 27;   // scale * kbit/s
    localparam int DVS_W  = 16;   // sample rate in Hz
    localparam int QUO_W  = 11;   // quotient bits of the frame size
    localparam int BIT_W  = 4;    // index of one quotient bit
    localparam int POS_W  = 6;    // byte position within the capture
    localparam int SIDE_TAPS = 12;

    // Byte positions.
    localparam logic [POS_W-1:0] HDR_LAST   = 6'd3;
    localparam logic [POS_W-1:0] SIDE_FIRST = 6'd4;

    typedef logic [POS_W-1:0] pos_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             cap_hdr;
        logic             cap_side;
        pos_t             wr_pos;
        logic             mul_load;
        logic             div_step;
        logic [BIT_W-1:0] div_bit;
        logic             res_ok;
        logic             res_bad;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_ok;
        logic last_byte;
    } stat_t;

    // Bitrate in kbit/s.
    function automatic logic [8:0] rate_kbps(input logic [1:0] ver, input logic [3:0] br);
        logic [8:0] r;
        r = 9'd0;
        if (ver == VER_MPEG1)
        begin
            case (br)
                4'd1:    r = 9'd32;
                4'd2:    r = 9'd40;
                4'd3:    r = 9'd48;
                4'd4:    r = 9'd56;
                4'd5:    r = 9'd64;
                4'd6:    r = 9'd80;
                4'd7:    r = 9'd96;
                4'd8:    r = 9'd112;
                4'd9:    r = 9'd128;
                4'd10:   r = 9'd160;
                4'd11:   r = 9'd192;
                4'd12:   r = 9'd224;
                4'd13:   r = 9'd256;
                4'd14:   r = 9'd320;
                default: r = 9'd0;
            endcase
        end
        else
        begin
            case (br)
                4'd1:    r = 9'd8;
                4'd2:    r = 9'd16;
                4'd3:    r = 9'd24;
                4'd4:    r = 9'd32;
                4'd5:    r = 9'd40;
                4'd6:    r = 9'd48;
                4'd7:    r = 9'd56;
                4'd8:    r = 9'd64;
                4'd9:    r = 9'd80;
                4'd10:   r = 9'd96;
                4'd11:   r = 9'd112;
                4'd12:   r = 9'd128;
                4'd13:   r = 9'd144;
                4'd14:   r = 9'd160;
                default: r = 9'd0;
            endcase
        end
        return r;
    endfunction

    // Sample rate in Hz.
    function automatic logic [DVS_W-1:0] fs_hz(input logic [1:0] ver, input logic [1:0] sr);
        logic [DVS_W-1:0] f;
        f = '0;
        case (ver)
            2'd3:
            begin
                case (sr)
                    2'd0:    f = 16'd44100;
                    2'd1:    f = 16'd48000;
                    2'd2:    f = 16'd32000;
                    default: f = 16'd0;
                endcase
            end
            2'd2:
            begin
                case (sr)
                    2'd0:    f = 16'd22050;
                    2'd1:    f = 16'd24000;
                    2'd2:    f = 16'd16000;
                    default: f = 16'd0;
                endcase
            end
            2'd0:
            begin
                case (sr)
                    2'd0:    f = 16'd11025;
                    2'd1:    f = 16'd12000;
                    2'd2:    f = 16'd8000;
                    default: f = 16'd0;
                endcase
            end
            default: f = 16'd0;
        endcase
        return f;
    endfunction

endpackage

/* rtl/mp3fh_in_if.sv */
// ============================================================================
// mp3fh_in_if
// Byte stream channel: valid/ready handshake with one byte and a start flag.
// ============================================================================
interface mp3fh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

/* rtl/mp3fh_out_if.sv */
// ============================================================================
// mp3fh_out_if
// Result channel: valid/ready handshake with the decoded frame description.
// ============================================================================
interface mp3fh_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [10:0] frame_bytes;
    logic [2:0]  header_bytes;
    logic [5:0]  side_info_bytes;
    logic [8:0]  main_data_begin;
    logic [11:0] main_data_bytes;
    logic        version_mpeg1;

    modport source (output valid, output valid_res, output frame_bytes, output header_bytes,
                    output side_info_bytes, output main_data_begin,
                    output main_data_bytes, output version_mpeg1, input ready);
    modport sink   (input valid, input valid_res, input frame_bytes, input header_bytes,
                    input side_info_bytes, input main_data_begin,
                    input main_data_bytes, input version_mpeg1, output ready);
endinterface

/* rtl/mp3_frame_header_analyzer.sv */
// ============================================================================
// mp3_frame_header_analyzer
// Parses MPEG audio Layer III frame headers and side information from a byte
// stream and reports frame size, header and side-info lengths, main-data
// begin and main-data length.
// ============================================================================
//
//  Channel   Role    Moves per transfer
//  -------   -----   ------------------------------------------------------
//  stream    sink    one stream byte plus a frame start flag
//  result    source  one frame description (or an invalid-header report)
//
//  Header bytes and side-info bytes are taken one per cycle. After the fourth
//  header byte the input stalls: one multiplier forms the numerator, the
//  restoring divider runs (one quotient bit per cycle) and the size is
//  checked. A result waits in an output register; header bytes are still
//  taken while it waits, but side-info bytes and an invalid-header report
//  hold until that register is free.
//  Reset is asynchronous and active low; there is no clearing pass after it.
//
module mp3_frame_header_analyzer
#(
    parameter int unsigned MAX_FRAME_BYTES = mp3fh_pkg::MAX_FRAME_BYTES
)
(
    input  logic         clk,
    input  logic         rst_n,
    mp3fh_in_if.sink     stream,
    mp3fh_out_if.source  result
);

    mp3fh_pkg::cmd_t  cmd;
    mp3fh_pkg::stat_t stat;

    // The controller owns all handshakes and sequencing; the datapath only
    // reacts to the command word.
    mp3fh_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stream.valid),
        .in_start  (stream.frame_start),
        .in_ready  (stream.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Capture registers, frame size arithmetic and the result register.
    mp3fh_dp
    #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    )
    u_dp
    (
        .clk             (clk),
        .data_byte       (stream.data_byte),
        .cmd             (cmd),
        .stat            (stat),
        .valid_res       (result.valid_res),
        .frame_bytes     (result.frame_bytes),
        .header_bytes    (result.header_bytes),
        .side_info_bytes (result.side_info_bytes),
        .main_data_begin (result.main_data_begin),
        .main_data_bytes (result.main_data_bytes),
        .version_mpeg1   (result.version_mpeg1)
    );

`ifndef ASSERT_OFF
    // An invalid-header report carries all-zero fields.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.valid_res |->
            result.frame_bytes == '0 && result.header_bytes == '0 &&
            result.side_info_bytes == '0 && result.main_data_bytes == '0 &&
            result.main_data_begin == '0 && !result.version_mpeg1)
        else $error("invalid-header result with nonzero fields");

    // A valid frame always lies within the size limits and has a legal header length.
    a_good_size: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.valid_res |->
            result.frame_bytes >= 11'(mp3fh_pkg::MIN_FRAME_BYTES) &&
            result.frame_bytes <= 11'(MAX_FRAME_BYTES) &&
            (result.header_bytes == 3'd4 || result.header_bytes == 3'd6))
        else $error("valid result with out-of-range size or header length");

    // No byte is taken while the divider is running.
    a_div_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step || cmd.mul_load |-> !stream.ready)
        else $error("input accepted during frame size computation");

    // A result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_ok || cmd.res_bad) |-> (!result.valid || result.ready))
        else $error("result register overwritten before transfer");
`endif

endmodule

/* rtl/mp3fh_dp.sv */
// ============================================================================
// mp3fh_dp
// Datapath: header and side-info capture, frame size multiply and restoring
// divide, size checks and the result register.
// ============================================================================
module mp3fh_dp
#(
    parameter int unsigned MAX_FRAME_BYTES = mp3fh_pkg::MAX_FRAME_BYTES
)
(
    input  logic               clk,
    input  logic [7:0]         data_byte,
    input  mp3fh_pkg::cmd_t    cmd,
    output mp3fh_pkg::stat_t   stat,
    output logic               valid_res,
    output logic [10:0]        frame_bytes,
    output logic [2:0]         header_bytes,
    output logic [5:0]         side_info_bytes,
    output logic [8:0]         main_data_begin,
    output logic [11:0]        main_data_bytes,
    output logic               version_mpeg1
);

    // Side-info byte offsets that feed main_data_begin and part2_3_length.
    localparam logic [mp3fh_pkg::SIDE_TAPS-1:0][5:0] SIDE_OFS =
        {6'd26, 6'd25, 6'd24, 6'd18, 6'd17, 6'd11, 6'd10, 6'd9, 6'd3, 6'd2, 6'd1, 6'd0};

    logic [7:0] hdr_reg [4];
    logic [7:0] sd_reg  [mp3fh_pkg::SIDE_TAPS];

    logic [mp3fh_pkg::NUM_W-1:0] rem_reg;
    logic [mp3fh_pkg::DVS_W-1:0] dvs_reg;
    logic [mp3fh_pkg::QUO_W-1:0] quo_reg;

    logic [10:0] sync;
    logic [1:0]  ver;
    logic        prot;
    logic [3:0]  br;
    logic [1:0]  sr;
    logic        pad;
    logic        mono;
    logic        v1;
    logic        pre_ok;
    logic [17:0] scale;
    logic [mp3fh_pkg::NUM_W-1:0] num;
    logic [mp3fh_pkg::NUM_W-1:0] trial;
    logic [11:0] size;
    logic [2:0]  hlen;
    logic [5:0]  slen;
    logic [5:0]  need_m1;
    logic [5:0]  rel;
    logic [11:0] p0, p1, p2, p3;
    logic [14:0] bits_sum;
    logic [14:0] bits_rnd;
    logic [8:0]  mdb;

    assign sync   = {hdr_reg[0], hdr_reg[1][7:5]};
    assign ver    = hdr_reg[1][4:3];
    assign prot   = hdr_reg[1][0];
    assign br     = hdr_reg[2][7:4];
    assign sr     = hdr_reg[2][3:2];
    assign pad    = hdr_reg[2][1];
    assign mono   = (hdr_reg[3][7:6] == mp3fh_pkg::MODE_MONO);
    assign v1     = (ver == mp3fh_pkg::VER_MPEG1);
    assign pre_ok = (sync == mp3fh_pkg::SYNC_WORD) && (ver != mp3fh_pkg::VER_RESERVED)
                    && (br != mp3fh_pkg::BR_FREE) && (br != mp3fh_pkg::BR_BAD)
                    && (sr != mp3fh_pkg::SR_RESERVED);

    assign scale = v1 ? mp3fh_pkg::SCALE_MPEG1 : mp3fh_pkg::SCALE_MPEG2;
    assign num   = {9'd0, scale} * {18'd0, mp3fh_pkg::rate_kbps(ver, br)};
    assign trial = {{(mp3fh_pkg::NUM_W - mp3fh_pkg::DVS_W){1'b0}}, dvs_reg} << cmd.div_bit;

    assign size  = {1'b0, quo_reg} + {11'd0, pad};
    assign stat.frame_ok = pre_ok && (size >= 12'(mp3fh_pkg::MIN_FRAME_BYTES))
                           && (size <= 12'(MAX_FRAME_BYTES));

    assign hlen    = prot ? 3'd4 : 3'd6;
    assign slen    = v1 ? (mono ? 6'd17 : 6'd32) : (mono ? 6'd9 : 6'd17);
    assign need_m1 = {3'd0, hlen} + slen - 6'd1;
    assign stat.last_byte = (cmd.wr_pos == need_m1);
    assign rel     = cmd.wr_pos - {3'd0, hlen};

    // Part2_3_length fields; the layout depends on version and channel mode.
    always_comb
    begin
        p0 = '0;
        p1 = '0;
        p2 = '0;
        p3 = '0;
        if (!v1)
        begin
            if (mono)
            begin
                p0 = {sd_reg[1][6:0], sd_reg[2][7:3]};
            end
            else
            begin
                p0 = {sd_reg[1][5:0], sd_reg[2][7:2]};
                p1 = {sd_reg[4][6:0], sd_reg[5][7:3]};
            end
        end
        else if (mono)
        begin
            p0 = {sd_reg[2][5:0], sd_reg[3][7:2]};
            p1 = {sd_reg[4][2:0], sd_reg[5], sd_reg[6][7]};
        end
        else
        begin
            p0 = {sd_reg[2][3:0], sd_reg[3]};
            p1 = {sd_reg[4][0], sd_reg[5], sd_reg[6][7:5]};
            p2 = {sd_reg[7][5:0], sd_reg[8][7:2]};
            p3 = {sd_reg[9][2:0], sd_reg[10], sd_reg[11][7]};
        end
    end

    // Four full-scale fields plus the rounding term need 15 bits.
    assign bits_sum = {3'd0, p0} + {3'd0, p1} + {3'd0, p2} + {3'd0, p3};
    assign bits_rnd = bits_sum + 15'd7;
    assign mdb      = v1 ? {sd_reg[0], sd_reg[1][7]} : {1'b0, sd_reg[0]};

    always_ff @(posedge clk)
    begin
        if (cmd.cap_hdr)
        begin
            hdr_reg[cmd.wr_pos[1:0]] <= data_byte;
        end
        if (cmd.cap_side)
        begin
            for (int k = 0; k < mp3fh_pkg::SIDE_TAPS; k++)
            begin
                if (rel == SIDE_OFS[k])
                begin
                    sd_reg[k] <= data_byte;
                end
            end
        end
    end

    // One quotient bit per cycle, most significant first.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            rem_reg <= num;
            dvs_reg <= mp3fh_pkg::fs_hz(ver, sr);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg              <= rem_reg - trial;
                quo_reg[cmd.div_bit] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_bad)
        begin
            valid_res       <= 1'b0;
            frame_bytes     <= '0;
            header_bytes    <= '0;
            side_info_bytes <= '0;
            main_data_begin <= '0;
            main_data_bytes <= '0;
            version_mpeg1   <= 1'b0;
        end
        else if (cmd.res_ok)
        begin
            valid_res       <= 1'b1;
            frame_bytes     <= size[10:0];
            header_bytes    <= hlen;
            side_info_bytes <= slen;
            main_data_begin <= mdb;
            main_data_bytes <= bits_rnd[14:3];
            version_mpeg1   <= v1;
        end
    end

endmodule

/* rtl/mp3fh_ctrl.sv */
// ============================================================================
// mp3fh_ctrl
// Controller: sequences header capture, the frame size divide, side-info
// capture and the result hand-off.
// ============================================================================
module mp3fh_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_start,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    input  mp3fh_pkg::stat_t  stat,
    output mp3fh_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {IDLE, HDR, MUL, DIV, CHK, SIDE} state_t;

    state_t                      state_reg, state_next;
    mp3fh_pkg::pos_t             pos_reg, pos_next;
    logic [mp3fh_pkg::BIT_W-1:0] cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_free;
    logic                        load;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.wr_pos = pos_reg;
        in_ready   = 1'b0;
        load       = 1'b0;
        case (state_reg)
            IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && in_start)
                begin
                    cmd.cap_hdr = 1'b1;
                    cmd.wr_pos  = '0;
                    pos_next    = mp3fh_pkg::pos_t'(1);
                    state_next  = HDR;
                end
            end
            HDR:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap_hdr = 1'b1;
                    if (in_start)
                    begin
                        cmd.wr_pos = '0;
                        pos_next   = mp3fh_pkg::pos_t'(1);
                    end
                    else if (pos_reg == mp3fh_pkg::HDR_LAST)
                    begin
                        state_next = MUL;
                    end
                    else
                    begin
                        pos_next = pos_reg + mp3fh_pkg::pos_t'(1);
                    end
                end
            end
            MUL:
            begin
                cmd.mul_load = 1'b1;
                cnt_next     = mp3fh_pkg::BIT_W'(mp3fh_pkg::QUO_W - 1);
                state_next   = DIV;
            end
            DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_bit  = cnt_reg;
                if (cnt_reg == '0)
                begin
                    state_next = CHK;
                end
                else
                begin
                    cnt_next = cnt_reg - mp3fh_pkg::BIT_W'(1);
                end
            end
            CHK:
            begin
                if (stat.frame_ok)
                begin
                    pos_next   = mp3fh_pkg::SIDE_FIRST;
                    state_next = SIDE;
                end
                else if (out_free)
                begin
                    cmd.res_bad = 1'b1;
                    load        = 1'b1;
                    state_next  = IDLE;
                end
            end
            SIDE:
            begin
                in_ready = out_free;
                if (in_valid && out_free)
                begin
                    if (in_start)
                    begin
                        cmd.cap_hdr = 1'b1;
                        cmd.wr_pos  = '0;
                        pos_next    = mp3fh_pkg::pos_t'(1);
                        state_next  = HDR;
                    end
                    else
                    begin
                        cmd.cap_side = 1'b1;
                        if (stat.last_byte)
                        begin
                            cmd.res_ok = 1'b1;
                            load       = 1'b1;
                            state_next = IDLE;
                        end
                        else
                        begin
                            pos_next = pos_reg + mp3fh_pkg::pos_t'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* tb/sv/tb_mp3_frame_header_analyzer.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_mp3_frame_header_analyzer
// Self-checking bench for the Layer III frame header analyzer. A short
// directed table covers the header error cases and a restarted capture.
// Random frames, broken frames and line noise follow. Every result transfer
// is compared field by field with a cycle-free parser model or a row's report.
// ============================================================================
module tb_mp3_frame_header_analyzer;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int CAP_DEPTH      = 38;   // longest header plus side info
    localparam int HDR_LEN_FIXED  = 4;    // bytes before the header is checked
    localparam int HDR_NO_CRC     = 4;
    localparam int HDR_WITH_CRC   = 6;
    localparam int SIDE_V1_MONO   = 17;
    localparam int SIDE_V1_STEREO = 32;
    localparam int SIDE_V2_MONO   = 9;
    localparam int SIDE_V2_STEREO = 17;
    localparam int SLOT_SCALE_V1  = 144;
    localparam int SLOT_SCALE_V2  = 72;

    localparam int RANDOM_ITEMS   = 1200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;   // size stall plus margin
    localparam int DIR_ROWS       = 23;

    localparam logic [1:0] VER_MPEG2  = 2'd2;
    localparam logic [1:0] VER_MPEG25 = 2'd0;

    // Bit rates in kbit/s and sample rates in Hz, indexed by header fields.
    localparam int unsigned KBPS_MPEG1 [16] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128,
                                               160, 192, 224, 256, 320, 0};
    localparam int unsigned KBPS_MPEG2 [16] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80,
                                               96, 112, 128, 144, 160, 0};
    localparam int unsigned FS_HZ [4][4] = '{'{11025, 12000, 8000, 0},
                                            '{0, 0, 0, 0},
                                            '{22050, 24000, 16000, 0},
                                            '{44100, 48000, 32000, 0}};

    // One frame description as the result channel carries it.
    typedef struct packed {
        logic        valid_res;
        logic [10:0] frame_bytes;
        logic [2:0]  header_bytes;
        logic [5:0]  side_info_bytes;
        logic [8:0]  main_data_begin;
        logic [11:0] main_data_bytes;
        logic        version_mpeg1;
    } frame_desc_t;

    // A rejected header reports zero in every field.
    localparam frame_desc_t INVALID_REPORT = '0;

    // One stream byte to send. A typed row carries its expected report
    // directly; every other byte is checked against the model below.
    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic        typed;
        frame_desc_t want;
    } stim_t;

    // ------------------------------------------------------------------------
    // Clock, reset and channels
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    mp3fh_in_if  stream_if ();
    mp3fh_out_if result_if ();

    // Bench-side drivers, known from time zero.
    logic       src_valid = 1'b0;
    logic [7:0] src_data  = 8'h00;
    logic       src_start = 1'b0;
    logic       snk_ready = 1'b0;

    assign stream_if.valid       = src_valid;
    assign stream_if.data_byte   = src_data;
    assign stream_if.frame_start = src_start;
    assign result_if.ready       = snk_ready;

    mp3_frame_header_analyzer dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if)
    );

    // ------------------------------------------------------------------------
    // Frame parser model
    // ------------------------------------------------------------------------
    // The model keeps its own copy of the capture store. It is stepped once
    // per accepted byte transfer and produces at most one frame description.
    logic [7:0] cap_mem [CAP_DEPTH] = '{default: 8'h00};
    logic [5:0] cap_pos  = '0;
    logic       cap_busy = 1'b0;

    function automatic int unsigned cap_at(input int unsigned idx);
        return (idx < CAP_DEPTH) ? int'(cap_mem[idx]) : 0;
    endfunction

    function automatic int unsigned hdr_len_of(input logic [7:0] b1);
        return b1[0] ? HDR_NO_CRC : HDR_WITH_CRC;
    endfunction

    function automatic int unsigned side_len_of(input logic [7:0] b1, input logic [7:0] b3);
        logic mono;
        mono = (b3[7:6] == mp3fh_pkg::MODE_MONO);
        if (b1[4:3] == mp3fh_pkg::VER_MPEG1)
            return mono ? SIDE_V1_MONO : SIDE_V1_STEREO;
        return mono ? SIDE_V2_MONO : SIDE_V2_STEREO;
    endfunction

    // Frame length in bytes, or zero when the header must be rejected.
    function automatic int unsigned frame_len_of();
        logic [1:0]  ver;
        logic [3:0]  br;
        logic [1:0]  sr;
        int unsigned rate;
        int unsigned fs;
        int unsigned size;
        ver = cap_mem[1][4:3];
        br  = cap_mem[2][7:4];
        sr  = cap_mem[2][3:2];
        if ({cap_mem[0], cap_mem[1][7:5]} != mp3fh_pkg::SYNC_WORD)
            return 0;
        if (ver == mp3fh_pkg::VER_RESERVED || br == mp3fh_pkg::BR_FREE
            || br == mp3fh_pkg::BR_BAD || sr == mp3fh_pkg::SR_RESERVED)
            return 0;
        rate = ((ver == mp3fh_pkg::VER_MPEG1) ? KBPS_MPEG1[br] : KBPS_MPEG2[br]) * 1000;
        fs   = FS_HZ[ver][sr];
        if (fs == 0)
            return 0;
        size = ((ver == mp3fh_pkg::VER_MPEG1) ? SLOT_SCALE_V1 : SLOT_SCALE_V2) * rate / fs
               + int'(cap_mem[2][1]);
        if (size < mp3fh_pkg::MIN_FRAME_BYTES || size > mp3fh_pkg::MAX_FRAME_BYTES)
            return 0;
        return size;
    endfunction

    // Sum of the part2_3_length fields of all granules and channels, rounded
    // up to whole bytes. The field positions depend on version and mode.
    function automatic int unsigned main_len_of(input int unsigned h, input logic mpeg1,
                                                input logic mono);
        int unsigned bits;
        bits = 0;
        if (!mpeg1)
        begin
            if (mono)
                bits = ((cap_at(h + 1) & 'h7F) << 5) | (cap_at(h + 2) >> 3);
            else
            begin
                bits = ((cap_at(h + 1) & 'h3F) << 6) | (cap_at(h + 2) >> 2);
                bits += ((cap_at(h + 9) & 'h7F) << 5) | (cap_at(h + 10) >> 3);
            end
        end
        else if (mono)
        begin
            bits = ((cap_at(h + 2) & 'h3F) << 6) | (cap_at(h + 3) >> 2);
            bits += ((cap_at(h + 9) & 'h07) << 9) | (cap_at(h + 10) << 1)
                    | (cap_at(h + 11) >> 7);
        end
        else
        begin
            bits = ((cap_at(h + 2) & 'h0F) << 8) | cap_at(h + 3);
            bits += ((cap_at(h + 9) & 'h01) << 11) | (cap_at(h + 10) << 3)
                    | (cap_at(h + 11) >> 5);
            bits += ((cap_at(h + 17) & 'h3F) << 6) | (cap_at(h + 18) >> 2);
            bits += ((cap_at(h + 24) & 'h07) << 9) | (cap_at(h + 25) << 1)
                    | (cap_at(h + 26) >> 7);
        end
        return (bits + 7) >> 3;
    endfunction

    task automatic parse_stream_byte(input logic [7:0] b, input logic s,
                                     output logic got, output frame_desc_t d);
        int unsigned size;
        int unsigned hl;
        int unsigned sl;
        logic        v1;
        got = 1'b0;
        d   = INVALID_REPORT;
        // A start flag always opens a new capture, dropping any running one.
        if (s)
        begin
            cap_busy = 1'b1;
            cap_pos  = '0;
        end
        if (cap_busy)
        begin
            if (cap_pos < CAP_DEPTH)
                cap_mem[cap_pos] = b;
            cap_pos = cap_pos + 6'd1;
            if (cap_pos >= HDR_LEN_FIXED)
            begin
                size = frame_len_of();
                hl   = hdr_len_of(cap_mem[1]);
                sl   = side_len_of(cap_mem[1], cap_mem[3]);
                if (size == 0)
                begin
                    // Rejected header: an all-zero report right away.
                    got      = 1'b1;
                    cap_busy = 1'b0;
                    cap_pos  = '0;
                end
                else if (cap_pos >= hl + sl)
                begin
                    v1                = (cap_mem[1][4:3] == mp3fh_pkg::VER_MPEG1);
                    d.valid_res       = 1'b1;
                    d.frame_bytes     = size[10:0];
                    d.header_bytes    = hl[2:0];
                    d.side_info_bytes = sl[5:0];
                    d.main_data_begin = v1 ? 9'((cap_at(hl) << 1) | (cap_at(hl + 1) >> 7))
                                           : 9'(cap_at(hl));
                    d.main_data_bytes = 12'(main_len_of(hl, v1,
                                            cap_mem[3][7:6] == mp3fh_pkg::MODE_MONO));
                    d.version_mpeg1   = v1;
                    got      = 1'b1;
                    cap_busy = 1'b0;
                    cap_pos  = '0;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    frame_desc_t pending_desc_q [$];
    int          mismatch_cnt = 0;

    task automatic report_field(input string fname, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, fname, want, got);
            mismatch_cnt++;
        end
    endtask

    task automatic check_result();
        frame_desc_t want;
        if (pending_desc_q.size() == 0)
        begin
            $display("%0t ns: result with nothing expected, expected none, %s%0d %s%0d",
                     $time, "actual valid_res=", result_if.valid_res,
                     "frame_bytes=", result_if.frame_bytes);
            mismatch_cnt++;
        end
        else
        begin
            want = pending_desc_q.pop_front();
            report_field("valid_res",       want.valid_res,       result_if.valid_res);
            report_field("frame_bytes",     want.frame_bytes,     result_if.frame_bytes);
            report_field("header_bytes",    want.header_bytes,    result_if.header_bytes);
            report_field("side_info_bytes", want.side_info_bytes, result_if.side_info_bytes);
            report_field("main_data_begin", want.main_data_begin, result_if.main_data_begin);
            report_field("main_data_bytes", want.main_data_bytes, result_if.main_data_bytes);
            report_field("version_mpeg1",   want.version_mpeg1,   result_if.version_mpeg1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Clocked bench logic: sender, receiver, model stepping and watchdog
    // ------------------------------------------------------------------------
    // Everything that samples the channels lives in this one block, so the
    // model and the checker see transfers in a fixed order. Channel values
    // are read before the edge updates land, and every driven signal gets
    // a single nonblocking assignment per edge.
    stim_t byte_stream_q [$];
    stim_t cur_item;
    int    src_burst_left = 1;
    int    src_gap_left   = 0;
    int    snk_mode       = 0;
    int    snk_mode_left  = 0;
    int    snk_stall_left = 0;
    int    cycle_cnt      = 0;
    int    idle_cycles    = 0;

    always @(posedge clk)
    begin
        logic        got;
        frame_desc_t pred;
        logic        moved;
        logic        next_valid;
        logic        next_ready;
        moved = 1'b0;
        if (rst_n)
        begin
            cycle_cnt++;

            if (result_if.valid && result_if.ready)
            begin
                check_result();
                moved = 1'b1;
            end

            if (stream_if.valid && stream_if.ready)
            begin
                parse_stream_byte(stream_if.data_byte, stream_if.frame_start, got, pred);
                if (cur_item.typed)
                    pending_desc_q.push_back(cur_item.want);
                else if (got)
                    pending_desc_q.push_back(pred);
                moved = 1'b1;
            end

            // Sender: bursts of random length, separated by random gaps. A byte
            // that has not been taken yet stays on the channel unchanged.
            if (!(stream_if.valid && !stream_if.ready))
            begin
                next_valid = 1'b0;
                if (src_gap_left > 0)
                    src_gap_left--;
                else if (byte_stream_q.size() != 0)
                begin
                    cur_item   = byte_stream_q.pop_front();
                    next_valid = 1'b1;
                    src_data  <= cur_item.data;
                    src_start <= cur_item.start;
                    src_burst_left--;
                    if (src_burst_left <= 0)
                    begin
                        src_burst_left = $urandom_range(40, 1);
                        src_gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
                    end
                end
                src_valid <= next_valid;
            end

            // Receiver: the stall pattern is redrawn at random, when its period ends,
            // among always ready, coin flips, long stalls and a fixed 3-of-5 rhythm.
            if (snk_mode_left == 0)
            begin
                snk_mode      = $urandom_range(3, 0);
                snk_mode_left = 256;
            end
            snk_mode_left--;
            case (snk_mode)
                0: next_ready = 1'b1;
                1: next_ready = 1'($urandom);
                2:
                begin
                    if (snk_stall_left == 0)
                    begin
                        next_ready     = 1'b1;
                        snk_stall_left = $urandom_range(24, 1);
                    end
                    else
                    begin
                        next_ready = 1'b0;
                        snk_stall_left--;
                    end
                end
                default: next_ready = ((cycle_cnt % 5) < 3);
            endcase
            snk_ready <= next_ready;

            // Watchdog on cycles without any transfer on either channel.
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------
    int items_made = 0;

    task automatic push_byte(input logic [7:0] b, input logic s, input logic counted);
        byte_stream_q.push_back('{b, s, 1'b0, INVALID_REPORT});
        if (counted)
            items_made++;
    endtask

    // A header that passes every check. A few come out at the longest and
    // the shortest frame the block accepts.
    function automatic logic [31:0] make_valid_header();
        logic [1:0] ver;
        logic [3:0] br;
        logic [1:0] sr;
        logic       pad;
        int         sel;
        sel = $urandom_range(99, 0);
        case ($urandom_range(2, 0))
            0:       ver = VER_MPEG25;
            1:       ver = VER_MPEG2;
            default: ver = mp3fh_pkg::VER_MPEG1;
        endcase
        br  = 4'($urandom_range(mp3fh_pkg::BR_BAD - 1, mp3fh_pkg::BR_FREE + 1));
        sr  = 2'($urandom_range(mp3fh_pkg::SR_RESERVED - 1, 0));
        pad = 1'($urandom);
        if (sel < 8)
        begin
            // 320 kbit/s at 32 kHz with padding: the largest frame.
            ver = mp3fh_pkg::VER_MPEG1;
            br  = mp3fh_pkg::BR_BAD - 4'd1;
            sr  = 2'd2;
            pad = 1'b1;
        end
        else if (sel < 16)
        begin
            // 8 kbit/s at 24 kHz without padding: the smallest frame.
            ver = VER_MPEG2;
            br  = mp3fh_pkg::BR_FREE + 4'd1;
            sr  = 2'd1;
            pad = 1'b0;
        end
        return {mp3fh_pkg::SYNC_WORD, ver, 2'($urandom), 1'($urandom), br, sr, pad,
                1'($urandom), 8'($urandom)};
    endfunction

    // Break exactly one of the checked header fields.
    function automatic logic [31:0] corrupt_header(input logic [31:0] hdr);
        logic [31:0] h;
        int          k;
        h = hdr;
        k = $urandom_range(10, 0);
        case ($urandom_range(4, 0))
            0:       h[21 + k] = ~h[21 + k];
            1:       h[20:19]  = mp3fh_pkg::VER_RESERVED;
            2:       h[15:12]  = mp3fh_pkg::BR_FREE;
            3:       h[15:12]  = mp3fh_pkg::BR_BAD;
            default: h[11:10]  = mp3fh_pkg::SR_RESERVED;
        endcase
        return h;
    endfunction

    // Send the first total bytes of a frame: header, then side information
    // that is random, all ones or all zeros.
    task automatic push_frame(input logic [31:0] hdr, input int total);
        int fill;
        fill = $urandom_range(9, 0);
        for (int i = 0; i < total; i++)
        begin
            if (i < HDR_LEN_FIXED)
                push_byte(hdr[31 - 8 * i -: 8], i == 0, 1'b1);
            else if (fill < 2)
                push_byte(8'hFF, 1'b0, 1'b1);
            else if (fill < 3)
                push_byte(8'h00, 1'b0, 1'b1);
            else
                push_byte(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        stim_t       directed_rows [DIR_ROWS];
        logic [31:0] hdr;
        int          full;
        int          pick;
        logic        gen_idle;

        rst_n = 1'b0;

        // Directed part. The fourth byte of each rejected header carries
        // the all-zero report it must produce.
        directed_rows = '{
            // Byte while idle, no start flag: ignored.
            '{8'h55, 1'b0, 1'b0, INVALID_REPORT},
            // Sync word with its top bit cleared.
            '{8'h7F, 1'b1, 1'b0, INVALID_REPORT},
            '{8'hFB, 1'b0, 1'b0, INVALID_REPORT},
            '{8'h90, 1'b0, 1'b0, INVALID_REPORT},
            '{8'h00, 1'b0, 1'b1, INVALID_REPORT},
            // Two header bytes, then a new start drops that capture.
            '{8'hFF, 1'b1, 1'b0, INVALID_REPORT},
            '{8'hFB, 1'b0, 1'b0, INVALID_REPORT},
            // Reserved version.
            '{8'hFF, 1'b1, 1'b0, INVALID_REPORT},
            '{8'hEB, 1'b0, 1'b0, INVALID_REPORT},
            '{8'h90, 1'b0, 1'b0, INVALID_REPORT},
            '{8'h00, 1'b0, 1'b1, INVALID_REPORT},
            // Free-format bit rate.
            '{8'hFF, 1'b1, 1'b0, INVALID_REPORT},
            '{8'hF3, 1'b0, 1'b0, INVALID_REPORT},
            '{8'h04, 1'b0, 1'b0, INVALID_REPORT},
            '{8'h00, 1'b0, 1'b1, INVALID_REPORT},
            // Forbidden bit rate index.
            '{8'hFF, 1'b1, 1'b0, INVALID_REPORT},
            '{8'hFB, 1'b0, 1'b0, INVALID_REPORT},
            '{8'hF0, 1'b0, 1'b0, INVALID_REPORT},
            '{8'hFF, 1'b0, 1'b1, INVALID_REPORT},
            // Reserved sample rate index on an MPEG 2.5 header.
            '{8'hFF, 1'b1, 1'b0, INVALID_REPORT},
            '{8'hE3, 1'b0, 1'b0, INVALID_REPORT},
            '{8'h1C, 1'b0, 1'b0, INVALID_REPORT},
            '{8'h00, 1'b0, 1'b1, INVALID_REPORT}
        };
        for (int i = 0; i < DIR_ROWS; i++)
            byte_stream_q.push_back(directed_rows[i]);

        // Random part: mostly complete frames with random content, the rest
        // broken headers, cut-off frames, noise while idle and junk.
        gen_idle = 1'b1;
        while (items_made < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99, 0);
            hdr  = make_valid_header();
            full = hdr_len_of(hdr[23:16]) + side_len_of(hdr[23:16], hdr[7:0]);
            if (pick < 60)
            begin
                push_frame(hdr, full);
                gen_idle = 1'b1;
            end
            else if (pick < 72)
            begin
                push_frame(corrupt_header(hdr), HDR_LEN_FIXED);
                gen_idle = 1'b1;
            end
            else if (pick < 82)
            begin
                push_frame(hdr, $urandom_range(full - 1, 1));
                gen_idle = 1'b0;
            end
            else if (pick < 92)
            begin
                if (gen_idle)
                    repeat ($urandom_range(6, 1))
                        push_byte(8'($urandom), 1'b0, 1'b0);
            end
            else
            begin
                push_byte(8'($urandom), 1'b1, 1'b1);
                repeat ($urandom_range(7, 0))
                    push_byte(8'($urandom), $urandom_range(7, 0) == 0, 1'b1);
                gen_idle = 1'b0;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // The end conditions are polled on the falling edge, after all rising-edge updates.
        while (byte_stream_q.size() != 0 || src_valid)
            @(negedge clk);
        while (pending_desc_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_cnt == 0 && pending_desc_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
rtl/mp3fh_pkg.sv
rtl/mp3fh_in_if.sv
rtl/mp3fh_out_if.sv
rtl/mp3fh_dp.sv
rtl/mp3fh_ctrl.sv
rtl/mp3_frame_header_analyzer.sv
tb/sv/tb_mp3_frame_header_analyzer.sv
